@@ rtl/touch_point_coordinate_mapper_defines.svh @@
// Assertion macros shared by the touch point coordinate mapper RTL.
`ifndef TOUCH_POINT_COORDINATE_MAPPER_DEFINES_SVH
`define TOUCH_POINT_COORDINATE_MAPPER_DEFINES_SVH

// The condition must never be true outside reset.
`define TPCM_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define TPCM_ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tpcm_pkg.sv @@
package tpcm_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned NUM_AXES    = 2;

	typedef enum logic [2:0] {
		REG_MODE_FLAGS    = 3'd0,
		REG_SCREEN_WIDTH  = 3'd1,
		REG_SCREEN_HEIGHT = 3'd2,
		REG_OFFSET_X      = 3'd3,
		REG_OFFSET_Y      = 3'd4,
		REG_CAL_X_BOUNDS  = 3'd5,
		REG_CAL_Y_BOUNDS  = 3'd6,
		REG_MAX_TOUCH_ID  = 3'd7
	} reg_idx_t;

	// Bit positions in the mode register; the y variant sits one above the x one.
	localparam int unsigned MODE_FLIP_X = 0;
	localparam int unsigned MODE_FIT_X  = 2;
	localparam int unsigned MODE_CAL    = 4;

	localparam logic [4:0] MODE_RESET   = 5'b01100;
	localparam logic [3:0] MAX_ID_RESET = 4'd1;

	typedef enum logic [1:0] {
		EV_DOWN     = 2'd0,
		EV_LIFT     = 2'd1,
		EV_CONTACT  = 2'd2,
		EV_RESERVED = 2'd3
	} event_t;

	localparam logic [1:0] STATE_DOWN    = 2'd1;
	localparam logic [1:0] STATE_CONTACT = 2'd2;
	localparam logic [1:0] STATE_LIFT    = 2'd3;

	localparam logic [3:0] MAX_FRAME_TOUCHES = 4'd2;

	// Native panel size per axis and the matching reciprocal, ceil(2^32 / size).
	// For dividends below 2^24 the product shifted right by 32 is the exact quotient.
	localparam logic [11:0] NATIVE_SIZE [NUM_AXES]  = '{12'd240, 12'd320};
	localparam logic [24:0] NATIVE_RECIP [NUM_AXES] = '{25'd17895698, 25'd13421773};
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned FIT_QUO_W   = 17;

	// Calibration divider: numerator magnitude, denominator magnitude, quotient bits.
	localparam int unsigned CAL_NUM_W = 28;
	localparam int unsigned CAL_DEN_W = 16;
	localparam int unsigned CAL_QBITS = 12;

	typedef struct packed {
		logic [4:0]         mode;
		logic [11:0]        width;
		logic [11:0]        height;
		logic signed [12:0] off_x;
		logic signed [12:0] off_y;
		logic [31:0]        cal_x;
		logic [31:0]        cal_y;
		logic [3:0]         max_id;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  id;
		logic [11:0] x;
		logic [11:0] y;
		logic [1:0]  state;
	} item_t;

	typedef struct packed {
		logic [3:0] id;
		logic [1:0] state;
	} tag_t;

endpackage

@@ rtl/tpcm_front.sv @@
module tpcm_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        touch_count,
	input  logic [3:0]        record_index,
	input  logic [7:0]        x_high_byte,
	input  logic [7:0]        x_low_byte,
	input  logic [7:0]        y_high_byte,
	input  logic [7:0]        y_low_byte,
	input  logic [3:0]        max_touch_id,
	input  logic              q_full,
	output logic              push,
	output tpcm_pkg::item_t   push_item
);

	tpcm_pkg::event_t ev;
	logic             ev_ok;
	logic [1:0]       state;
	logic             count_ok;
	logic             keep;

	assign ev = tpcm_pkg::event_t'(x_high_byte[7:6]);

	always_comb begin
		unique case (ev)
			tpcm_pkg::EV_DOWN: begin
				state = tpcm_pkg::STATE_DOWN;
				ev_ok = 1'b1;
			end
			tpcm_pkg::EV_CONTACT: begin
				state = tpcm_pkg::STATE_CONTACT;
				ev_ok = 1'b1;
			end
			tpcm_pkg::EV_LIFT: begin
				state = tpcm_pkg::STATE_LIFT;
				ev_ok = 1'b1;
			end
			tpcm_pkg::EV_RESERVED: begin
				state = tpcm_pkg::STATE_DOWN;
				ev_ok = 1'b0;
			end
		endcase
	end

	assign count_ok = (touch_count != 4'd0) && (touch_count <= tpcm_pkg::MAX_FRAME_TOUCHES);
	assign keep = count_ok && (record_index < touch_count) &&
		(y_high_byte[7:4] <= max_touch_id) && ev_ok;

	// Dropped records are still taken from the input; they just never enter the queue.
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && keep;

	assign push_item.id    = y_high_byte[7:4];
	assign push_item.x     = {x_high_byte[3:0], x_low_byte};
	assign push_item.y     = {y_high_byte[3:0], y_low_byte};
	assign push_item.state = state;

endmodule

@@ rtl/tpcm_queue.sv @@
`include "touch_point_coordinate_mapper_defines.svh"

module tpcm_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tpcm_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            out_valid,
	output tpcm_pkg::item_t out_item
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tpcm_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`TPCM_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH), "queue count overflow")
	`TPCM_ASSERT_NEXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "queue count did not grow on push")
	`TPCM_ASSERT_NEXT(a_pop_shrinks, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1, "queue count did not shrink on pop")

endmodule

@@ rtl/tpcm_back.sv @@
`include "touch_point_coordinate_mapper_defines.svh"

module tpcm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tpcm_pkg::cfg_t     cfg,
	input  logic               q_valid,
	output logic               q_ready,
	input  tpcm_pkg::item_t    q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         touch_id,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [1:0]         touch_state
);

	localparam int unsigned QW   = tpcm_pkg::CAL_QBITS;
	localparam int unsigned NW   = tpcm_pkg::CAL_NUM_W;
	localparam int unsigned DW   = tpcm_pkg::CAL_DEN_W;
	localparam int unsigned DIV0 = 10;
	localparam int unsigned LAST = DIV0 + QW + 1;

	logic [LAST:1]      vld_s;
	tpcm_pkg::tag_t     tag_s [1:LAST];
	logic               adv;
	logic signed [15:0] pos_lane [tpcm_pkg::NUM_AXES];

	// The whole mapping pipe moves as one; it holds only while the output waits.
	assign adv       = !vld_s[LAST] || out_ready;
	assign q_ready   = adv;
	assign out_valid = vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAST-1:1], q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[1] <= '{id: q_item.id, state: q_item.state};
			for (int k = 2; k <= LAST; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	for (genvar a = 0; a < tpcm_pkg::NUM_AXES; a++) begin : g_lane
		logic [11:0]        size;
		logic [11:0]        raw;
		logic               flip_en;
		logic               fit_en;
		logic               cal_en;
		logic signed [12:0] off;
		logic [31:0]        bounds;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [12:0] sm1;
		logic signed [15:0] sm1_w;

		logic signed [12:0] v1_c;
		logic signed [25:0] prod_c;
		logic [24:0]        pabs_c;
		logic [48:0]        recip_c;
		logic signed [17:0] quo_c;
		logic signed [15:0] v2_c;
		logic signed [16:0] sum_c;
		logic signed [15:0] v3_c;
		logic signed [29:0] num_c;
		logic [29:0]        nabs_c;
		logic [16:0]        dabs_c;
		logic signed [QW:0] quo_ext;
		logic signed [15:0] pos_c;

		logic signed [12:0] v1_s1, v1_s2, v1_s3, v1_s4;
		logic signed [24:0] prod_s2;
		logic [23:0]        pabs_s3;
		logic               neg_s3, neg_s4;
		logic [tpcm_pkg::FIT_QUO_W-1:0] quo_s4;
		logic signed [15:0] v2_s5;
		logic signed [15:0] v3_s [6:LAST-1];
		logic signed [16:0] diff_s7, den_s7, den_s8;
		logic signed [29:0] num_s8;
		logic [NW-1:0]      nabs_s9;
		logic [DW-1:0]      dabs_s9;
		logic               qneg_s9, dzero_s9;
		logic [NW-1:0]      rem_s   [DIV0:DIV0+QW];
		logic [DW-1:0]      dabs_s  [DIV0:DIV0+QW];
		logic [QW-1:0]      quo_s   [DIV0:DIV0+QW];
		logic               qneg_s  [DIV0:DIV0+QW];
		logic               dzero_s [DIV0:DIV0+QW];
		logic               big_s   [DIV0:DIV0+QW];
		logic signed [15:0] pos_s23;

		assign size    = (a == 0) ? cfg.width : cfg.height;
		assign raw     = (a == 0) ? q_item.x : q_item.y;
		assign off     = (a == 0) ? cfg.off_x : cfg.off_y;
		assign bounds  = (a == 0) ? cfg.cal_x : cfg.cal_y;
		assign flip_en = cfg.mode[tpcm_pkg::MODE_FLIP_X + a];
		assign fit_en  = cfg.mode[tpcm_pkg::MODE_FIT_X + a];
		assign cal_en  = cfg.mode[tpcm_pkg::MODE_CAL];
		assign lo      = $signed(bounds[15:0]);
		assign hi      = $signed(bounds[31:16]);
		// A zero screen size makes the upper bound -1.
		assign sm1     = $signed({1'b0, size}) - 13'sd1;
		assign sm1_w   = {{3{sm1[12]}}, sm1};

		always_comb begin
			v1_c = flip_en ? ($signed({1'b0, size}) - $signed({1'b0, raw}))
				: $signed({1'b0, raw});
			prod_c  = v1_s1 * $signed({1'b0, size});
			pabs_c  = prod_s2[24] ? 25'(-prod_s2) : 25'(prod_s2);
			recip_c = pabs_s3 * tpcm_pkg::NATIVE_RECIP[a];
			quo_c   = neg_s4 ? -$signed({1'b0, quo_s4}) : $signed({1'b0, quo_s4});
			if (fit_en && (size != tpcm_pkg::NATIVE_SIZE[a])) begin
				v2_c = quo_c[15:0];
			end else begin
				v2_c = {{3{v1_s4[12]}}, v1_s4};
			end

			// The offset wraps to 16 bits before the clamp; the upper bound wins.
			sum_c = {v2_s5[15], v2_s5} + {{4{off[12]}}, off};
			if (off == '0) begin
				v3_c = v2_s5;
			end else if ($signed(sum_c[15:0]) > sm1_w) begin
				v3_c = sm1_w;
			end else if (sum_c[15]) begin
				v3_c = '0;
			end else begin
				v3_c = sum_c[15:0];
			end

			num_c  = diff_s7 * sm1;
			nabs_c = num_s8[29] ? 30'(-num_s8) : 30'(num_s8);
			dabs_c = den_s8[16] ? 17'(-den_s8) : 17'(den_s8);

			// Clamp the truncated quotient: negative goes to zero, then the upper bound.
			quo_ext = $signed({1'b0, quo_s[DIV0+QW]});
			if (!cal_en) begin
				pos_c = v3_s[LAST-1];
			end else if (dzero_s[DIV0+QW]) begin
				pos_c = sm1[12] ? sm1_w : '0;
			end else if (qneg_s[DIV0+QW] &&
				(big_s[DIV0+QW] || (quo_s[DIV0+QW] != '0))) begin
				pos_c = '0;
			end else if (big_s[DIV0+QW] || (quo_ext > sm1)) begin
				pos_c = sm1_w;
			end else begin
				pos_c = {{(16-QW){1'b0}}, quo_s[DIV0+QW]};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				v1_s1    <= v1_c;
				v1_s2    <= v1_s1;
				prod_s2  <= prod_c[24:0];
				v1_s3    <= v1_s2;
				pabs_s3  <= pabs_c[23:0];
				neg_s3   <= prod_s2[24];
				v1_s4    <= v1_s3;
				neg_s4   <= neg_s3;
				quo_s4   <= recip_c[tpcm_pkg::RECIP_SHIFT +: tpcm_pkg::FIT_QUO_W];
				v2_s5    <= v2_c;
				v3_s[6]  <= v3_c;
				for (int k = 7; k <= LAST - 1; k++) begin
					v3_s[k] <= v3_s[k-1];
				end
				diff_s7  <= {v3_s[6][15], v3_s[6]} - {lo[15], lo};
				den_s7   <= {hi[15], hi} - {lo[15], lo};
				num_s8   <= num_c;
				den_s8   <= den_s7;
				nabs_s9  <= nabs_c[NW-1:0];
				dabs_s9  <= dabs_c[DW-1:0];
				qneg_s9  <= num_s8[29] ^ den_s8[16];
				dzero_s9 <= (den_s8 == '0);
				// A quotient of 2^QW or more always clamps, so only QW bits are formed.
				rem_s[DIV0]   <= nabs_s9;
				dabs_s[DIV0]  <= dabs_s9;
				quo_s[DIV0]   <= '0;
				qneg_s[DIV0]  <= qneg_s9;
				dzero_s[DIV0] <= dzero_s9;
				big_s[DIV0]   <= (nabs_s9 >= {dabs_s9, {QW{1'b0}}});
				pos_s23       <= pos_c;
			end
		end

		// Restoring division, one quotient bit per stage, most significant first.
		for (genvar st = DIV0 + 1; st <= DIV0 + QW; st++) begin : g_div
			localparam int unsigned SHIFT_AMT = DIV0 + QW - st;
			logic [NW-1:0] dsh;
			logic [NW:0]   trial;

			assign dsh   = NW'(dabs_s[st-1]) << SHIFT_AMT;
			assign trial = {1'b0, rem_s[st-1]} - {1'b0, dsh};

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[st]   <= trial[NW] ? rem_s[st-1] : trial[NW-1:0];
					quo_s[st]   <= {quo_s[st-1][QW-2:0], !trial[NW]};
					dabs_s[st]  <= dabs_s[st-1];
					qneg_s[st]  <= qneg_s[st-1];
					dzero_s[st] <= dzero_s[st-1];
					big_s[st]   <= big_s[st-1];
				end
			end
		end

		assign pos_lane[a] = pos_s23;
	end

	assign pos_x       = pos_lane[0];
	assign pos_y       = pos_lane[1];
	assign touch_id    = tag_s[LAST].id;
	assign touch_state = tag_s[LAST].state;

	`TPCM_ASSERT_NEXT(a_stall_holds, clk, arst_n, !adv, vld_s == $past(vld_s), "pipeline moved while stalled")
	`TPCM_ASSERT_NEXT(a_pop_enters, clk, arst_n, q_valid && adv, vld_s[1], "popped item did not enter the pipeline")

endmodule

@@ rtl/touch_point_coordinate_mapper.sv @@
// A kept record passes from the input through the record queue and the mapping pipeline
// to the output; the twelve-stage calibration divider makes up most of that pipeline.
// Throughput: one record per cycle while the queue has room; a dropped record is taken and gives no result.
// The mapping pipeline holds as a whole while a result waits, and the input keeps
// filling the record queue until it is full.
// Reset (arst_n low) empties the queue and pipeline and restores register defaults at once.
module touch_point_coordinate_mapper #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [tpcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tpcm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [3:0]                        touch_count,
	input  logic [3:0]                        record_index,
	input  logic [7:0]                        x_high_byte,
	input  logic [7:0]                        x_low_byte,
	input  logic [7:0]                        y_high_byte,
	input  logic [7:0]                        y_low_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3:0]                        touch_id,
	output logic signed [15:0]                pos_x,
	output logic signed [15:0]                pos_y,
	output logic [1:0]                        touch_state
);

	tpcm_pkg::cfg_t  cfg_q;
	tpcm_pkg::item_t push_item;
	tpcm_pkg::item_t q_item;
	logic            push;
	logic            q_full;
	logic            q_valid;
	logic            q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= tpcm_pkg::MODE_RESET;
			cfg_q.width  <= tpcm_pkg::NATIVE_SIZE[0];
			cfg_q.height <= tpcm_pkg::NATIVE_SIZE[1];
			cfg_q.off_x  <= '0;
			cfg_q.off_y  <= '0;
			cfg_q.cal_x  <= '0;
			cfg_q.cal_y  <= '0;
			cfg_q.max_id <= tpcm_pkg::MAX_ID_RESET;
		end else if (cfg_wen) begin
			unique case (tpcm_pkg::reg_idx_t'(cfg_index))
				tpcm_pkg::REG_MODE_FLAGS:    cfg_q.mode   <= cfg_data[4:0];
				tpcm_pkg::REG_SCREEN_WIDTH:  cfg_q.width  <= cfg_data[11:0];
				tpcm_pkg::REG_SCREEN_HEIGHT: cfg_q.height <= cfg_data[11:0];
				tpcm_pkg::REG_OFFSET_X:      cfg_q.off_x  <= $signed(cfg_data[12:0]);
				tpcm_pkg::REG_OFFSET_Y:      cfg_q.off_y  <= $signed(cfg_data[12:0]);
				tpcm_pkg::REG_CAL_X_BOUNDS:  cfg_q.cal_x  <= cfg_data[31:0];
				tpcm_pkg::REG_CAL_Y_BOUNDS:  cfg_q.cal_y  <= cfg_data[31:0];
				tpcm_pkg::REG_MAX_TOUCH_ID:  cfg_q.max_id <= cfg_data[3:0];
			endcase
		end
	end

	tpcm_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.touch_count  (touch_count),
		.record_index (record_index),
		.x_high_byte  (x_high_byte),
		.x_low_byte   (x_low_byte),
		.y_high_byte  (y_high_byte),
		.y_low_byte   (y_low_byte),
		.max_touch_id (cfg_q.max_id),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	tpcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_valid && q_ready),
		.out_valid (q_valid),
		.out_item  (q_item)
	);

	tpcm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_item      (q_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.touch_id    (touch_id),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.touch_state (touch_state)
	);

endmodule
